### rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse unit.
package mi3_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 28;
  localparam int NELEM     = 9;

  // Multiplier split into 24-bit limbs.
  localparam int LIMB = 24;
  localparam int MA_W = WORD_BITS;
  localparam int MB_W = 2 * WORD_BITS;
  localparam int MP_W = MA_W + MB_W;
  localparam int NA   = MA_W / LIMB;
  localparam int NB   = MB_W / LIMB;
  localparam int RS_W = MB_W + LIMB;

  localparam int CF_W   = 2 * WORD_BITS;
  localparam int DET_W  = MP_W + 2;
  localparam int DMAG_W = DET_W - 1;
  localparam int NUM_W  = CF_W + FRAC_BITS;
  localparam int RW     = DMAG_W + WORD_BITS;

  localparam int THR_W = 64;
  localparam logic [THR_W-1:0] THR_RESET = 64'd19342813113834;

  localparam int MUL_LAT  = 6;
  localparam int CF_LAT   = MUL_LAT + 1;
  localparam int DET_LAT  = 2 * MUL_LAT + 3;
  localparam int CF_DLY   = DET_LAT - CF_LAT;
  localparam int LANE_LAT = WORD_BITS + 2;
  localparam int LAT      = DET_LAT + LANE_LAT;

  // Cofactor k is a[CF_PA]*a[CF_PB] - a[CF_QA]*a[CF_QB], sign already folded in.
  localparam int CF_PA [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_PB [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_QA [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_QB [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [CF_W-1:0]      cf_t;
  typedef logic signed [MP_W-1:0]      prod_t;
  typedef logic signed [DET_W-1:0]     det_t;
  typedef logic        [DMAG_W-1:0]    dmag_t;

endpackage

### rtl/mi3_mul.sv
// Pipelined signed 48x96 multiplier built from 24x24 limb products.
module mi3_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [mi3_pkg::MA_W-1:0] a,
  input  logic signed [mi3_pkg::MB_W-1:0] b,
  output logic signed [mi3_pkg::MP_W-1:0] p
);
  import mi3_pkg::*;

  logic [MA_W-1:0]     am;
  logic [MB_W-1:0]     bm;
  logic [2*LIMB-1:0]   pp [NA][NB];
  logic [3*LIMB-1:0]   ps [NA][NB/2];
  logic [RS_W-1:0]     rs [NA];
  logic [MP_W-1:0]     mg;
  logic [4:0]          sg;

  always_ff @(posedge clk) begin
    if (en) begin
      am <= a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
      bm <= b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
      sg <= {sg[3:0], a[MA_W-1] ^ b[MB_W-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= am[LIMB*i +: LIMB] * bm[LIMB*j +: LIMB];
        end
        for (int k = 0; k < NB/2; k++) begin
          ps[i][k] <= (3*LIMB)'(pp[i][2*k]) + ((3*LIMB)'(pp[i][2*k+1]) << LIMB);
        end
        rs[i] <= RS_W'(ps[i][0]) + (RS_W'(ps[i][1]) << (2*LIMB));
      end
      mg <= MP_W'(rs[0]) + (MP_W'(rs[1]) << LIMB);
      p  <= sg[4] ? -$signed(mg) : $signed(mg);
    end
  end

endmodule

### rtl/mi3_div_lane.sv
// One division lane: cofactor times 2^FRAC_BITS over the determinant, one quotient bit a stage.
module mi3_div_lane (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [mi3_pkg::CF_W-1:0] cf,
  input  logic [mi3_pkg::DMAG_W-1:0]      dmag,
  input  logic                            dneg,
  output logic signed [mi3_pkg::WORD_BITS-1:0] q_out,
  output logic                            sat
);
  import mi3_pkg::*;

  localparam int QB = WORD_BITS;

  logic [NUM_W-1:0]  rem [QB+1];
  logic [DMAG_W-1:0] den [QB+1];
  logic [QB-1:0]     q   [QB+1];
  logic              qn  [QB+1];
  logic              ov  [QB+1];

  logic [CF_W-1:0] nmag;
  logic [NUM_W-1:0] num;
  logic [QB-1:0]   lim;
  logic            clamp;
  logic [QB-1:0]   qsel;

  always_comb begin
    nmag = cf[CF_W-1] ? CF_W'(-cf) : CF_W'(cf);
    num  = {nmag, FRAC_BITS'(0)};
  end

  // A quotient of 2^QB or more can only saturate, so it is flagged up front.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      den[0] <= dmag;
      q[0]   <= '0;
      qn[0]  <= cf[CF_W-1] ^ dneg;
      ov[0]  <= RW'(num) >= {dmag, QB'(0)};
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int K = QB - s;
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      trial = RW'(den[s-1]) << K;
      take  = RW'(rem[s-1]) >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? NUM_W'(RW'(rem[s-1]) - trial) : rem[s-1];
        q[s]   <= take ? (q[s-1] | (QB'(1) << K)) : q[s-1];
        den[s] <= den[s-1];
        qn[s]  <= qn[s-1];
        ov[s]  <= ov[s-1];
      end
    end
  end

  always_comb begin
    lim   = qn[QB] ? (QB'(1) << (QB-1)) : ((QB'(1) << (QB-1)) - QB'(1));
    clamp = ov[QB] || (q[QB] > lim);
    qsel  = clamp ? lim : q[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= qn[QB] ? -$signed(qsel) : $signed(qsel);
      sat   <= clamp;
    end
  end

endmodule

### rtl/matrix3x3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit: cofactors, determinant, division lanes, merge.
//
//  channel  | dir | signals                          | content
//  s_*      | in  | tvalid tready tdata[431:0]       | a00..a22, 48 bits each
//  m_*      | out | tvalid tready tdata[431:0] tuser | b00..b22; singular, saturated
//  cfg_*    | in  | cfg_we cfg_wdata[63:0]           | singular threshold
//
// One matrix is taken per cycle while the output register is not stalled. The path has
// 66 register stages, the first loaded by the input transfer itself:
// two 6-stage multiplier passes, 3 stages of cofactor and determinant sums, 50 stages
// through the bit-per-stage dividers, and the merge register.
// Reset clears the valid pipeline and loads the default threshold.
// A stalled output register holds the whole pipeline, and s_tready follows it.
module matrix3x3_inverse_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [431:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [431:0] m_tdata,   // b00, b01, b02, b10, b11, b12, b20, b21, b22
  output logic [1:0]   m_tuser,   // singular, saturated
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);
  import mi3_pkg::*;

  logic             en;
  logic [LAT-1:0]   vpipe;
  logic [THR_W-1:0] thr;

  word_t ain  [NELEM];
  word_t adly [CF_LAT][3];
  prod_t pa   [NELEM];
  prod_t pb   [NELEM];
  cf_t   cf   [NELEM];
  cf_t   cdly [CF_DLY][NELEM];
  prod_t dp   [3];
  det_t  det;
  det_t  dabs;
  dmag_t dmag;
  logic  dneg;
  logic  sing;
  logic  sdly [LANE_LAT];
  word_t lq   [NELEM];
  logic  lsat [NELEM];
  logic  any_sat;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vpipe    <= {vpipe[LAT-2:0], s_tvalid};
      m_tvalid <= vpipe[LAT-1];
    end
  end

  for (genvar i = 0; i < NELEM; i++) begin : g_in
    assign ain[i] = $signed(s_tdata[WORD_BITS*i +: WORD_BITS]);
  end

  // Cofactor products.
  for (genvar k = 0; k < NELEM; k++) begin : g_cf
    mi3_mul u_pa (
      .clk (clk), .en (en),
      .a   (ain[CF_PA[k]]),
      .b   (MB_W'(ain[CF_PB[k]])),
      .p   (pa[k])
    );
    mi3_mul u_pb (
      .clk (clk), .en (en),
      .a   (ain[CF_QA[k]]),
      .b   (MB_W'(ain[CF_QB[k]])),
      .p   (pb[k])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        cf[k] <= CF_W'(pa[k] - pb[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        adly[0][j] <= ain[j];
      end
      for (int s = 1; s < CF_LAT; s++) begin
        adly[s] <= adly[s-1];
      end
      cdly[0] <= cf;
      for (int s = 1; s < CF_DLY; s++) begin
        cdly[s] <= cdly[s-1];
      end
    end
  end

  // Determinant by expansion along the first row.
  for (genvar j = 0; j < 3; j++) begin : g_det
    mi3_mul u_dm (
      .clk (clk), .en (en),
      .a   (adly[CF_LAT-1][j]),
      .b   (cf[3*j]),
      .p   (dp[j])
    );
  end

  always_comb begin
    dabs = det[DET_W-1] ? -det : det;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det  <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      dneg <= det[DET_W-1];
      dmag <= DMAG_W'(dabs);
      sing <= (dabs == '0) ||
              ((dabs[DET_W-1:THR_W] == '0) && (dabs[THR_W-1:0] < thr));
      sdly[0] <= sing;
      for (int s = 1; s < LANE_LAT; s++) begin
        sdly[s] <= sdly[s-1];
      end
    end
  end

  for (genvar k = 0; k < NELEM; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cf    (cdly[CF_DLY-1][k]),
      .dmag  (dmag),
      .dneg  (dneg),
      .q_out (lq[k]),
      .sat   (lsat[k])
    );
  end

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < NELEM; k++) begin
      any_sat = any_sat | lsat[k];
    end
  end

  // Merge: a singular matrix gives all-zero elements and no saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NELEM; k++) begin
        m_tdata[WORD_BITS*k +: WORD_BITS] <= sdly[LANE_LAT-1] ? '0 : lq[k];
      end
      m_tuser <= {!sdly[LANE_LAT-1] && any_sat, sdly[LANE_LAT-1]};
    end
  end

endmodule

### verif/tb_matrix3x3_inverse_unit.sv
// Testbench for the 3x3 matrix inverse unit: random and directed matrices checked against an exact adjugate predictor.
module tb_matrix3x3_inverse_unit;
  import mi3_pkg::*;

  typedef word_t mat_t [NELEM];
  typedef logic signed [255:0] wide_t;

  typedef struct {
    word_t b [NELEM];
    logic  singular;
    logic  saturated;
  } inverse_t;

  class inverse_scoreboard;
    logic [THR_W-1:0] threshold;
    inverse_t expected_q [$];
    int errors;

    function new();
      threshold = THR_RESET;
      errors = 0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Exact adjugate over wide integers, then a truncating quotient per element.
    function void note(mat_t m);
      wide_t a [NELEM];
      wide_t cof [NELEM];
      wide_t det, dmag, mag, quo, lim;
      logic dneg, qneg;
      inverse_t r;
      for (int i = 0; i < NELEM; i++) a[i] = m[i];
      cof[0] = a[4] * a[8] - a[5] * a[7];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[2] * a[3] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[4] * a[6];
      cof[7] = a[1] * a[6] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      dneg = det < 0;
      dmag = dneg ? -det : det;
      r.singular = 0;
      r.saturated = 0;
      if (dmag == 0 || $unsigned(dmag) < {192'd0, threshold}) begin
        r.singular = 1;
        for (int i = 0; i < NELEM; i++) r.b[i] = '0;
      end else begin
        for (int i = 0; i < NELEM; i++) begin
          qneg = (cof[i] < 0) != dneg;
          mag = (cof[i] < 0) ? -cof[i] : cof[i];
          quo = $unsigned(mag <<< FRAC_BITS) / $unsigned(dmag);
          lim = (wide_t'(1) <<< (WORD_BITS - 1)) - (qneg ? 0 : 1);
          if (quo > lim) begin
            quo = lim;
            r.saturated = 1;
          end
          r.b[i] = word_t'(qneg ? -quo : quo);
        end
      end
      expected_q.push_back(r);
    endfunction

    task check(logic [431:0] data, logic [1:0] user);
      inverse_t e;
      if (expected_q.size() == 0) begin
        report("result transfer with no matrix outstanding");
        return;
      end
      e = expected_q.pop_front();
      for (int i = 0; i < NELEM; i++)
        if (data[i*WORD_BITS +: WORD_BITS] !== e.b[i])
          report($sformatf("element %0d got %h expected %h", i,
                           data[i*WORD_BITS +: WORD_BITS], e.b[i]));
      if (user[0] !== e.singular)
        report($sformatf("singular got %b expected %b", user[0], e.singular));
      if (user[1] !== e.saturated)
        report($sformatf("saturated got %b expected %b", user[1], e.saturated));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [431:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [431:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 0;
  logic [63:0]  cfg_wdata = '0;

  int tx_idle_pct = 24;
  int rx_idle_pct = 56;
  int rx_hold_cycles = 0;
  inverse_scoreboard inv_sb = new();

  matrix3x3_inverse_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_tready = 0;
      rx_hold_cycles--;
    end else begin
      m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) inv_sb.check(m_tdata, m_tuser);

  task send_matrix(mat_t m);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    for (int i = 0; i < NELEM; i++) s_tdata[i*WORD_BITS +: WORD_BITS] = m[i];
    s_tvalid = 1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    inv_sb.note(m);
    @(negedge clk);
  endtask

  task write_threshold(logic [63:0] value);
    cfg_we = 1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    inv_sb.threshold = value;
  endtask

  // Waits for every outstanding result, then lets the pipeline run empty.
  task drain;
    s_tvalid = 0;
    while (inv_sb.expected_q.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
  endtask

  function word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  function word_t rand_range(int bits);
    return word_t'($signed({$urandom, $urandom}) >>> (64 - bits));
  endfunction

  function mat_t diag(word_t d0, word_t d1, word_t d2);
    mat_t m;
    foreach (m[i]) m[i] = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  function mat_t random_matrix();
    mat_t m;
    int kind;
    kind = $urandom_range(0, 9);
    foreach (m[i]) begin
      case (kind)
        0, 1:    m[i] = rand_word();
        2:       m[i] = rand_range(22);
        3:       m[i] = ($urandom_range(0, 1)) ? word_t'(1 <<< 47) : word_t'((1 <<< 47) - 1);
        default: m[i] = rand_range(30);
      endcase
    end
    if (kind >= 4 && kind <= 7) begin
      // Diagonal offset by one: plus one at a00 and a11, minus one at a22.
      m[0] += word_t'(1 <<< FRAC_BITS);
      m[4] += word_t'(1 <<< FRAC_BITS);
      m[8] -= word_t'(1 <<< FRAC_BITS);
    end else if (kind == 8) begin
      // Rank deficient: third row is the sum of the first two.
      for (int c = 0; c < 3; c++) m[6+c] = m[c] + m[3+c];
    end
    return m;
  endfunction

  task directed_matrices;
    mat_t m;
    word_t one;
    one = word_t'(1 <<< FRAC_BITS);
    send_matrix(diag(one, one, one));
    send_matrix(diag(-one, one, -one));
    send_matrix(diag(0, 0, 0));
    send_matrix(diag(1, 1, 1));
    send_matrix(diag(1 <<< 10, 1 <<< 10, 1 <<< 10));
    send_matrix(diag(one, one, 1 <<< 14));
    send_matrix(diag(one <<< 4, one <<< 6, -(one <<< 3)));
    send_matrix(diag(word_t'(1 <<< 47), word_t'(1 <<< 47), word_t'(1 <<< 47)));
    send_matrix(diag(word_t'((1 <<< 47) - 1), word_t'(1 <<< 47), one));
    foreach (m[i]) m[i] = word_t'((1 <<< 47) - 1);
    send_matrix(m);
    foreach (m[i]) m[i] = word_t'(1 <<< 47);
    send_matrix(m);
    m = diag(0, 0, 0);
    m[1] = one; m[5] = -one; m[6] = one;
    send_matrix(m);
    foreach (m[i]) m[i] = word_t'((i + 1) * (i + 3)) * one;
    send_matrix(m);
    foreach (m[i]) m[i] = (i % 2) ? -one : word_t'(i * 12345);
    send_matrix(m);
    foreach (m[i]) m[i] = rand_word();
    send_matrix(m);
  endtask

  task random_matrices(int count, bit pressure);
    for (int n = 0; n < count; n++) begin
      if (pressure && n == 40) rx_hold_cycles = 300;
      send_matrix(random_matrix());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed_matrices();
    drain();
    write_threshold(64'd0);
    directed_matrices();
    random_matrices(580, 1);
    drain();

    tx_idle_pct = 56;
    rx_idle_pct = 24;
    write_threshold(64'hFFFF_FFFF_FFFF_FFFF);
    random_matrices(600, 0);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_threshold({$urandom_range(0, 'hFFFF), $urandom});
    directed_matrices();
    random_matrices(600, 1);
    drain();

    if (inv_sb.errors == 0 && inv_sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
